### hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define CFA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked check that also holds across reset.
`define CFA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/cfa_pkg.sv
// Types and codes shared by the contiguous fit allocator.
package cfa_pkg;

   // Request kinds.
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   // Placement policies held in the mode register.
   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_mode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   localparam int OWNER_ID_W    = 16;
   localparam int BLOCK_SIZE_W  = 11;
   localparam int START_CELL_W  = 10;
   localparam int CELLS_FREED_W = 11;

   typedef logic [OWNER_ID_W-1:0]    owner_id_type;
   typedef logic [BLOCK_SIZE_W-1:0]  block_size_type;
   typedef logic [START_CELL_W-1:0]  start_cell_type;
   typedef logic [CELLS_FREED_W-1:0] cells_freed_type;

   // Request beat.
   typedef struct packed {
      req_kind_type   req_type;
      owner_id_type   owner_id;
      block_size_type block_size;
   } req_type;

   // Response beat.
   typedef struct packed {
      status_type      status;
      start_cell_type  start_cell;
      cells_freed_type cells_freed;
   } rsp_type;

endpackage

### hw/rtl/contiguous_fit_allocator_unit.sv
// Contiguous fit allocator: owner map in a RAM, scanned by a sequencer.
//
// Request channel (req_*): allocate (owner id, size) or clear by owner id.
// Response channel (rsp_*): one beat per request with status, start cell
// and freed-cell count. csr_wr_en/csr_wr_data set the fit policy
// (first, best, worst); write it only while the block is idle.
//
// One request at a time. An allocate scans the owner map one cell per cycle
// through the RAM read port (first fit may stop at the first fitting run),
// then writes block_size cells, one per cycle on the write port, and moves
// to the done state, which loads the response into the output register
// once that register is free. A clear reads and frees in one pass.
// Rejected requests go straight to the done state.
//
// After reset the block sweeps zeros into all MEM_CELLS entries with
// req_stall high. A finished response waits in an output register while
// rsp_stall is high; the next request is already accepted and worked on,
// and its result waits until the register frees.
`include "assert_macros.svh"

module contiguous_fit_allocator_unit
   import cfa_pkg::*;
#(
   parameter int MEM_CELLS  = 1024,
   parameter int OWNER_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   localparam int AW = $clog2(MEM_CELLS);
   localparam int CW = $clog2(MEM_CELLS + 1);
   localparam int LW = (CW > BLOCK_SIZE_W) ? CW : BLOCK_SIZE_W;

   typedef enum logic [5:0] {
      S_INIT  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_FILL  = 6'b001000,
      S_CLEAR = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type             state_ff,       state_in;
   logic [CW-1:0]         pos_ff,         pos_in;
   logic [OWNER_BITS-1:0] id_ff,          id_in;
   logic [LW-1:0]         want_ff,        want_in;
   logic [AW-1:0]         run_start_ff,   run_start_in;
   logic [CW-1:0]         run_len_ff,     run_len_in;
   logic                  found_ff,       found_in;
   logic [AW-1:0]         pick_start_ff,  pick_start_in;
   logic [CW-1:0]         best_len_ff,    best_len_in;
   logic [AW-1:0]         fill_addr_ff,   fill_addr_in;
   logic [CW-1:0]         freed_ff,       freed_in;
   rsp_type               res_ff,         res_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   rsp_type               rsp_data_ff,    rsp_data_in;
   logic [1:0]            fit_mode_ff;

   logic                  ram_we;
   logic [AW-1:0]         ram_wr_addr;
   logic [OWNER_BITS-1:0] ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [OWNER_BITS-1:0] ram_rd_data;

   logic                  req_accept;
   logic [OWNER_BITS-1:0] id_cut;
   logic                  mode_ok;
   logic [AW-1:0]         pos_lo;
   logic                  cell_free;
   logic                  fits;
   logic                  take;
   logic                  hit;
   logic [CW-1:0]         freed_next;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign id_cut  = OWNER_BITS'(req_data.owner_id);
   assign mode_ok = (fit_mode_ff == FIT_FIRST) || (fit_mode_ff == FIT_BEST) ||
                    (fit_mode_ff == FIT_WORST);
   assign pos_lo  = pos_ff[AW-1:0];

   // Classify the cell whose read data is arriving.
   assign cell_free  = (pos_ff != CW'(MEM_CELLS)) && (ram_rd_data == '0);
   assign fits       = (LW'(run_len_ff) >= want_ff);
   assign hit        = (ram_rd_data == id_ff);
   assign freed_next = freed_ff + CW'(hit);

   // Decide whether a closing run replaces the current pick.
   always_comb begin
      take = !found_ff;
      case (fit_mode_ff)
         FIT_BEST:  take = !found_ff || (run_len_ff < best_len_ff);
         FIT_WORST: take = !found_ff || (run_len_ff > best_len_ff);
         default:   take = !found_ff;
      endcase
   end

   cfa_owner_ram #(
      .DEPTH (MEM_CELLS),
      .WIDTH (OWNER_BITS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequence init sweep, scan, fill and clear passes.
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      id_in         = id_ff;
      want_in       = want_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      found_in      = found_ff;
      pick_start_in = pick_start_ff;
      best_len_in   = best_len_ff;
      fill_addr_in  = fill_addr_ff;
      freed_in      = freed_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = pos_lo;
      ram_wr_data   = '0;
      ram_rd_addr   = pos_lo + AW'(1);

      // Drop the response beat once it is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
            if (pos_ff == CW'(MEM_CELLS - 1)) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end

         S_IDLE: begin
            ram_rd_addr = '0;
            if (req_accept) begin
               id_in         = id_cut;
               want_in       = LW'(req_data.block_size);
               pos_in        = '0;
               run_start_in  = '0;
               run_len_in    = '0;
               found_in      = 1'b0;
               pick_start_in = '0;
               best_len_in   = '0;
               freed_in      = '0;
               res_in        = '{status: ST_INVALID, start_cell: '0, cells_freed: '0};
               if (id_cut == '0) begin
                  state_in = S_DONE;
               end else if (req_data.req_type == REQ_CLEAR) begin
                  state_in = S_CLEAR;
               end else if ((req_data.block_size == '0) || !mode_ok) begin
                  state_in = S_DONE;
               end else if (LW'(req_data.block_size) > LW'(MEM_CELLS)) begin
                  res_in.status = ST_NOSPACE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (cell_free) begin
               // Extend the current free run.
               if (run_len_ff == '0) begin
                  run_start_in = pos_lo;
               end
               run_len_in = run_len_ff + CW'(1);
               pos_in     = pos_ff + CW'(1);
            end else begin
               // Close the run and keep it if the policy prefers it.
               run_len_in = '0;
               if (fits && take) begin
                  found_in      = 1'b1;
                  pick_start_in = run_start_ff;
                  best_len_in   = run_len_ff;
               end
               if ((pos_ff == CW'(MEM_CELLS)) ||
                   (fits && take && (fit_mode_ff == FIT_FIRST))) begin
                  if (found_ff || (fits && take)) begin
                     fill_addr_in = (fits && take) ? run_start_ff : pick_start_ff;
                     state_in     = S_FILL;
                  end else begin
                     res_in.status = ST_NOSPACE;
                     state_in      = S_DONE;
                  end
               end else begin
                  pos_in = pos_ff + CW'(1);
               end
            end
         end

         S_FILL: begin
            ram_we       = 1'b1;
            ram_wr_addr  = fill_addr_ff;
            ram_wr_data  = id_ff;
            fill_addr_in = fill_addr_ff + AW'(1);
            want_in      = want_ff - LW'(1);
            if (want_ff == LW'(1)) begin
               res_in.status     = ST_DONE;
               res_in.start_cell = start_cell_type'(pick_start_ff);
               state_in          = S_DONE;
            end
         end

         S_CLEAR: begin
            // Free a matching cell; the next read is at another address.
            if (hit) begin
               ram_we = 1'b1;
            end
            freed_in = freed_next;
            if (pos_ff == CW'(MEM_CELLS - 1)) begin
               res_in.status      = ST_DONE;
               res_in.cells_freed = cells_freed_type'(freed_next);
               state_in           = S_DONE;
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end

         S_DONE: begin
            // Load the result once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
            pos_in   = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fit_mode_ff  <= FIT_FIRST;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fit_mode_ff <= csr_wr_data;
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      want_ff       <= want_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      found_ff      <= found_in;
      pick_start_ff <= pick_start_in;
      best_len_ff   <= best_len_in;
      fill_addr_ff  <= fill_addr_in;
      freed_ff      <= freed_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   `CFA_ASSERT_ALWAYS(a_reset_starts_sweep, reset |=> (state_ff == S_INIT), "reset must start the clearing sweep")
   `CFA_ASSERT(a_run_within_scan, (state_ff == S_SCAN) |-> (run_len_ff <= pos_ff), "free run longer than cells scanned")
   `CFA_ASSERT(a_pick_fits, ((state_ff == S_SCAN) && found_ff) |-> (LW'(best_len_ff) >= want_ff), "picked run shorter than request")
   `CFA_ASSERT(a_fill_count_live, (state_ff == S_FILL) |-> (want_ff != '0), "fill pass with no cells left")

endmodule

### hw/rtl/cfa_owner_ram.sv
// Owner map storage: one write port, one read port, registered read data.
module cfa_owner_ram
   import cfa_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write the addressed entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data; a same-address write returns the old entry.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
